// ----- design/lbpd_pkg.sv -----
package lbpd_pkg;

	// number of LEDs that drive a mask bit (1..8); the mode registers stay eight
	localparam int LED_COUNT = 8;
	// ticks between two filter updates (1..7)
	localparam int SAMPLE_EVERY = 5;

	localparam int NUM_LEDS = 8;
	localparam int NUM_PATTERNS = 6;
	localparam int COMPOSITE_IDX = 5;
	localparam int SAMPLE_W = 12;
	localparam int DUTY_W = 8;
	localparam int MODE_W = 3;
	localparam int TIMER_W = 8;
	localparam int INDEX_W = 3;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
	localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd20;
	localparam logic [DUTY_W-1:0] DUTY_SCALE = 8'd250;
	localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;

	// pattern rows, also the mode codes
	localparam logic [2:0] PAT_ON = 3'd0;
	localparam logic [2:0] PAT_OFF = 3'd1;
	localparam logic [2:0] PAT_SLOW = 3'd2;
	localparam logic [2:0] PAT_MEDIUM = 3'd3;
	localparam logic [2:0] PAT_FAST = 3'd4;
	localparam logic [2:0] PAT_COMPOSITE = 3'd5;

	typedef enum logic [1:0] {
		PH_SLOW   = 2'd0,
		PH_MEDIUM = 2'd1,
		PH_FAST   = 2'd2
	} comp_phase_t;

	typedef struct packed {
		logic [TIMER_W-1:0] count;
		logic               lit;
		logic               wrapped;
	} timer_step_t;

	function automatic logic [TIMER_W-1:0] lit_len(input logic [2:0] row);
		case (row)
			PAT_ON:     lit_len = 8'd25;
			PAT_OFF:    lit_len = 8'd0;
			PAT_SLOW:   lit_len = 8'd25;
			PAT_MEDIUM: lit_len = 8'd12;
			PAT_FAST:   lit_len = 8'd8;
			default:    lit_len = 8'd6;
		endcase
	endfunction

	function automatic logic [TIMER_W-1:0] last_val(input logic [2:0] row);
		case (row)
			PAT_ON:     last_val = 8'd24;
			PAT_OFF:    last_val = 8'd255;
			PAT_SLOW:   last_val = 8'd49;
			PAT_MEDIUM: last_val = 8'd24;
			PAT_FAST:   last_val = 8'd15;
			default:    last_val = 8'd11;
		endcase
	endfunction

	// one tick of a pattern timer
	function automatic timer_step_t timer_step(input logic [TIMER_W-1:0] t,
			input logic [2:0] row);
		timer_step_t r;
		r.count = TIMER_W'(t + 8'd1);
		r.lit = 1'b0;
		r.wrapped = 1'b0;
		if (r.count < lit_len(row)) begin
			r.lit = 1'b1;
		end else if (r.count > last_val(row)) begin
			r.count = '0;
			r.lit = 1'b1;
			r.wrapped = 1'b1;
		end
		return r;
	endfunction

	// f*7/8 + s/8, both truncated
	function automatic logic [SAMPLE_W-1:0] lowpass(input logic [SAMPLE_W-1:0] f,
			input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W+2:0] f7;
		f7 = (SAMPLE_W+3)'(f) * (SAMPLE_W+3)'(7);
		return SAMPLE_W'((f7 >> 3) + (SAMPLE_W+3)'(s >> 3));
	endfunction

	// 250*f/4095; divide by 2^12-1 as (x + x/4096 + 1)/4096, exact for x < 4095*4096
	function automatic logic [DUTY_W-1:0] scale_duty(input logic [SAMPLE_W-1:0] f);
		logic [19:0] prod;
		logic [20:0] acc;
		prod = 20'(f) * 20'(DUTY_SCALE);
		acc = 21'(prod) + 21'(prod >> 12) + 21'd1;
		return DUTY_W'(acc >> 12);
	endfunction

endpackage

// ----- design/led_blink_pattern_dimmer_unit.sv -----
// LED blink pattern and dimmer. Every input item is one tick carrying two 12-bit converter
// samples; every tick advances six pattern timers (on, off, slow 50-tick, medium 25-tick,
// fast 16-tick blink, and a composite of one slow, two medium and three fast blinks), and
// every fifth tick low-pass filters each sample and rescales it to a duty of 0..250. Each
// item gives one result: the lit mask from the per-LED mode registers and the two group
// duties. An item goes through an input register and then a result register, which offers
// its result; while that result is held, the next item waits in the input register. A
// new item is taken every cycle as long as the result side keeps up; the timer, filter and
// duty updates all sit in the single stage between those two registers. Mode registers are
// written through the cfg channel, which is always ready and should only be used while no
// item is in flight.
module led_blink_pattern_dimmer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [11:0] sample_low_group, [23:12] sample_high_group
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] lit_mask, [15:8] bright_low_group,
	                                    // [23:16] bright_high_group
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	// mode registers
	logic [lbpd_pkg::MODE_W-1:0] mode_q [lbpd_pkg::NUM_LEDS];

	// tick state
	logic [lbpd_pkg::TIMER_W-1:0] timer_q [lbpd_pkg::NUM_PATTERNS];
	lbpd_pkg::comp_phase_t        phase_q;
	logic [1:0]                   repeats_q;
	logic [2:0]                   divider_q;
	logic [lbpd_pkg::SAMPLE_W-1:0] filt_low_q, filt_high_q;
	logic [lbpd_pkg::DUTY_W-1:0]   duty_low_q, duty_high_q;

	// input stage
	logic                          valid_s1;
	logic [lbpd_pkg::SAMPLE_W-1:0] sample_low_s1, sample_high_s1;

	// result stage
	logic                        valid_s2;
	logic [7:0]                  mask_s2;
	logic [lbpd_pkg::DUTY_W-1:0] bright_low_s2, bright_high_s2;

	logic advance;

	// next-state values
	logic [lbpd_pkg::TIMER_W-1:0]  timer_d [lbpd_pkg::NUM_PATTERNS];
	logic [lbpd_pkg::NUM_PATTERNS-1:0] lit;
	lbpd_pkg::comp_phase_t         phase_d;
	logic [1:0]                    repeats_d;
	logic [2:0]                    divider_d;
	logic                          do_sample;
	logic [lbpd_pkg::SAMPLE_W-1:0] filt_low_d, filt_high_d;
	logic [lbpd_pkg::DUTY_W-1:0]   duty_low_d, duty_high_d;
	logic [7:0]                    mask_d;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {bright_high_s2, bright_low_s2, mask_s2};

	// tick logic: timers, composite sequencer, filter, duty and mask
	always_comb begin
		lbpd_pkg::timer_step_t step;
		logic [2:0]            comp_row;
		logic [1:0]            rep_inc;

		for (int i = 0; i < lbpd_pkg::COMPOSITE_IDX; i++) begin
			step = lbpd_pkg::timer_step(timer_q[i], 3'(i));
			timer_d[i] = step.count;
			lit[i] = step.lit;
		end

		case (phase_q)
			lbpd_pkg::PH_SLOW:   comp_row = lbpd_pkg::PAT_SLOW;
			lbpd_pkg::PH_MEDIUM: comp_row = lbpd_pkg::PAT_MEDIUM;
			lbpd_pkg::PH_FAST:   comp_row = lbpd_pkg::PAT_FAST;
			default:             comp_row = lbpd_pkg::PAT_SLOW;
		endcase
		step = lbpd_pkg::timer_step(timer_q[lbpd_pkg::COMPOSITE_IDX], comp_row);
		timer_d[lbpd_pkg::COMPOSITE_IDX] = step.count;
		lit[lbpd_pkg::COMPOSITE_IDX] = step.lit;

		// one slow, two medium, three fast, then round again
		phase_d = phase_q;
		repeats_d = repeats_q;
		rep_inc = 2'(repeats_q + 2'd1);
		if (step.wrapped) begin
			case (phase_q)
				lbpd_pkg::PH_MEDIUM: begin
					repeats_d = rep_inc;
					if (rep_inc == 2'd2) begin
						phase_d = lbpd_pkg::PH_FAST;
						repeats_d = 2'd0;
					end
				end
				lbpd_pkg::PH_FAST: begin
					repeats_d = rep_inc;
					if (rep_inc == 2'd3) begin
						phase_d = lbpd_pkg::PH_SLOW;
						repeats_d = 2'd0;
					end
				end
				default: phase_d = lbpd_pkg::PH_MEDIUM;
			endcase
		end

		divider_d = 3'(divider_q + 3'd1);
		do_sample = (divider_d == 3'(lbpd_pkg::SAMPLE_EVERY));
		if (do_sample) begin
			divider_d = 3'd0;
		end
		filt_low_d  = lbpd_pkg::lowpass(filt_low_q, sample_low_s1);
		filt_high_d = lbpd_pkg::lowpass(filt_high_q, sample_high_s1);
		duty_low_d  = do_sample ? lbpd_pkg::scale_duty(filt_low_d) : duty_low_q;
		duty_high_d = do_sample ? lbpd_pkg::scale_duty(filt_high_d) : duty_high_q;

		// modes 6 and 7 keep their LED dark
		mask_d = '0;
		for (int i = 0; i < lbpd_pkg::LED_COUNT; i++) begin
			if (mode_q[i] < 3'(lbpd_pkg::NUM_PATTERNS)) begin
				mask_d[i] = lit[mode_q[i]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lbpd_pkg::NUM_LEDS; i++) begin
				mode_q[i] <= lbpd_pkg::MODE_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			mode_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lbpd_pkg::NUM_PATTERNS; i++) begin
				timer_q[i] <= '0;
			end
			phase_q     <= lbpd_pkg::PH_SLOW;
			repeats_q   <= '0;
			divider_q   <= '0;
			filt_low_q  <= lbpd_pkg::FULL_SCALE;
			filt_high_q <= lbpd_pkg::FULL_SCALE;
			duty_low_q  <= lbpd_pkg::DUTY_RESET;
			duty_high_q <= lbpd_pkg::DUTY_RESET;
		end else if (advance) begin
			for (int i = 0; i < lbpd_pkg::NUM_PATTERNS; i++) begin
				timer_q[i] <= timer_d[i];
			end
			phase_q   <= phase_d;
			repeats_q <= repeats_d;
			divider_q <= divider_d;
			if (do_sample) begin
				filt_low_q  <= filt_low_d;
				filt_high_q <= filt_high_d;
			end
			duty_low_q  <= duty_low_d;
			duty_high_q <= duty_high_d;
		end
	end

	// handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_low_s1  <= s_axis_tdata[11:0];
			sample_high_s1 <= s_axis_tdata[23:12];
		end
		if (advance) begin
			mask_s2        <= mask_d;
			bright_low_s2  <= duty_low_d;
			bright_high_s2 <= duty_high_d;
		end
	end

endmodule

// ----- dv/led_blink_pattern_dimmer_unit_tb.sv -----
`timescale 1ns / 100ps

module led_blink_pattern_dimmer_unit_tb;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT = 1000;   // cycles with no handshake at all before giving up
	localparam int HOLD_CYCLES = 80;     // long result-side hold-off
	localparam int TAIL_CYCLES = 8;      // settle time after the last result
	localparam int DIR_ROWS = 23;
	localparam int DIR_CFG_AT = 5;       // rows before this run with the reset modes
	localparam int NUM_PHASES = 8;

	// mode codes with no pattern behind them
	localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

	// per pattern row: ticks lit from the start of a period, and last timer value before wrap
	localparam logic [lbpd_pkg::NUM_PATTERNS-1:0][7:0] LIT_TICKS =
		{8'd6, 8'd8, 8'd12, 8'd25, 8'd0, 8'd25};
	localparam logic [lbpd_pkg::NUM_PATTERNS-1:0][7:0] WRAP_AT =
		{8'd11, 8'd15, 8'd24, 8'd49, 8'd255, 8'd24};

	typedef struct packed {
		logic [lbpd_pkg::DUTY_W-1:0] bright_high;
		logic [lbpd_pkg::DUTY_W-1:0] bright_low;
		logic [7:0]                  lit_mask;
	} tick_result_t;

	typedef struct packed {
		logic [lbpd_pkg::SAMPLE_W-1:0] lo;
		logic [lbpd_pkg::SAMPLE_W-1:0] hi;
		logic                          pinned;   // result typed in below rather than predicted
		tick_result_t                  want;
	} tick_row_t;

	typedef enum int {LEVEL_MIXED, LEVEL_LOW, LEVEL_HIGH} level_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [11:0] sample_low_group, [23:12] sample_high_group
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [7:0] lit_mask, [15:8] bright_low, [23:16] bright_high
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [2:0]  cfg_data = '0;

	// sideband travelling with each offered item: typed-in expectation for the table rows
	logic         pin_on = 1'b0;
	tick_result_t pin_want = '0;

	// stimulus knobs, set by the sender
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	int          mismatch_count = 0;
	int          quiet_cycles = 0;

	tick_result_t due_results [$];
	tick_row_t    dir_rows [DIR_ROWS];

	// model state of the block
	logic [2:0]                    mode_reg [lbpd_pkg::NUM_LEDS];
	logic [7:0]                    pat_count [lbpd_pkg::NUM_PATTERNS];
	lbpd_pkg::comp_phase_t         comp_phase;
	logic [1:0]                    comp_reps;
	logic [2:0]                    sample_div;
	logic [lbpd_pkg::SAMPLE_W-1:0] filt_low;
	logic [lbpd_pkg::SAMPLE_W-1:0] filt_high;
	logic [lbpd_pkg::DUTY_W-1:0]   duty_low;
	logic [lbpd_pkg::DUTY_W-1:0]   duty_high;

	led_blink_pattern_dimmer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------- model

	// one tick of pattern timer 'slot' timed by table row 'row'; returns {wrapped, lit}
	function automatic logic [1:0] advance_timer(input int slot, input int row);
		logic [7:0] t;
		t = pat_count[slot] + 8'd1;
		if (t < LIT_TICKS[row]) begin
			pat_count[slot] = t;
			return 2'b01;
		end
		if (t > WRAP_AT[row]) begin
			pat_count[slot] = '0;
			return 2'b11;
		end
		pat_count[slot] = t;
		return 2'b00;
	endfunction

	// first-order low-pass, weight 1/8 on the new sample, both parts truncated
	function automatic logic [lbpd_pkg::SAMPLE_W-1:0] smooth(
			input logic [lbpd_pkg::SAMPLE_W-1:0] f,
			input logic [lbpd_pkg::SAMPLE_W-1:0] s);
		int v;
		v = (int'(f) * 7) / 8 + int'(s) / 8;
		return lbpd_pkg::SAMPLE_W'(v);
	endfunction

	function automatic logic [lbpd_pkg::DUTY_W-1:0] to_duty(
			input logic [lbpd_pkg::SAMPLE_W-1:0] f);
		return lbpd_pkg::DUTY_W'((int'(lbpd_pkg::DUTY_SCALE) * int'(f))
			/ int'(lbpd_pkg::FULL_SCALE));
	endfunction

	// advance the model by one tick and return the result it should produce
	function automatic tick_result_t predict_tick(input logic [lbpd_pkg::SAMPLE_W-1:0] lo,
			input logic [lbpd_pkg::SAMPLE_W-1:0] hi);
		logic [lbpd_pkg::NUM_PATTERNS-1:0] lit_now;
		logic [1:0]                        step;
		int                                comp_row;
		tick_result_t                      r;
		for (int p = 0; p < lbpd_pkg::COMPOSITE_IDX; p++) begin
			step = advance_timer(p, p);
			lit_now[p] = step[0];
		end
		case (comp_phase)
			lbpd_pkg::PH_MEDIUM: comp_row = lbpd_pkg::PAT_MEDIUM;
			lbpd_pkg::PH_FAST:   comp_row = lbpd_pkg::PAT_FAST;
			default:             comp_row = lbpd_pkg::PAT_SLOW;   // slow, and the unused code
		endcase
		step = advance_timer(lbpd_pkg::COMPOSITE_IDX, comp_row);
		lit_now[lbpd_pkg::COMPOSITE_IDX] = step[0];
		// composite: one slow, two medium, three fast periods, then round again
		if (step[1]) begin
			case (comp_phase)
				lbpd_pkg::PH_MEDIUM: begin
					comp_reps = comp_reps + 2'd1;
					if (comp_reps == 2'd2) begin
						comp_phase = lbpd_pkg::PH_FAST;
						comp_reps = '0;
					end
				end
				lbpd_pkg::PH_FAST: begin
					comp_reps = comp_reps + 2'd1;
					if (comp_reps == 2'd3) begin
						comp_phase = lbpd_pkg::PH_SLOW;
						comp_reps = '0;
					end
				end
				default: comp_phase = lbpd_pkg::PH_MEDIUM;
			endcase
		end
		// samples only count on every SAMPLE_EVERY-th tick
		sample_div = sample_div + 3'd1;
		if (sample_div == lbpd_pkg::SAMPLE_EVERY) begin
			sample_div = '0;
			filt_low = smooth(filt_low, lo);
			filt_high = smooth(filt_high, hi);
			duty_low = to_duty(filt_low);
			duty_high = to_duty(filt_high);
		end
		// undefined modes leave their LED dark
		r.lit_mask = '0;
		for (int n = 0; n < lbpd_pkg::LED_COUNT; n++) begin
			if (mode_reg[n] < lbpd_pkg::NUM_PATTERNS && lit_now[mode_reg[n]])
				r.lit_mask[n] = 1'b1;
		end
		// duties go out whether or not anything is lit
		r.bright_low = duty_low;
		r.bright_high = duty_high;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// one monitor for all three channels, so a tick is predicted before its result can pop
	always @(posedge clk) begin
		tick_result_t predicted;
		tick_result_t got;
		tick_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				mode_reg[cfg_index] = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = predict_tick(s_axis_tdata[11:0], s_axis_tdata[23:12]);
				due_results.push_back(pin_on ? pin_want : predicted);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (due_results.size() == 0) begin
					report_mismatch("result with no tick pending", int'(m_axis_tdata), 0);
				end else begin
					want = due_results.pop_front();
					if (got.lit_mask !== want.lit_mask)
						report_mismatch("lit_mask", int'(got.lit_mask),
							int'(want.lit_mask));
					if (got.bright_low !== want.bright_low)
						report_mismatch("bright_low_group", int'(got.bright_low),
							int'(want.bright_low));
					if (got.bright_high !== want.bright_high)
						report_mismatch("bright_high_group", int'(got.bright_high),
							int'(want.bright_high));
				end
			end
		end
	end

	// watchdog: too long without any handshake means the block has hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- result side

	// random back-pressure, plus a long hold-off on request so the block backs up
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	// offer one tick and wait for it to be taken; tvalid stays up so the next item can follow
	task automatic push_tick(input logic [lbpd_pkg::SAMPLE_W-1:0] lo,
			input logic [lbpd_pkg::SAMPLE_W-1:0] hi,
			input logic pin, input tick_result_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hi, lo};
		pin_on <= pin;
		pin_want <= want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_drained;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// write all eight mode registers back to back; only called with the block idle
	task automatic load_modes(input logic [lbpd_pkg::NUM_LEDS-1:0][2:0] modes);
		cfg_valid <= 1'b1;
		for (int n = 0; n < lbpd_pkg::NUM_LEDS; n++) begin
			cfg_index <= 3'(n);
			cfg_data <= modes[n];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// low mostly keeps s/8 at zero (one sample in ten is random), so the filter decays toward zero duty
	function automatic logic [lbpd_pkg::SAMPLE_W-1:0] pick_sample(input level_t lv);
		case (lv)
			LEVEL_LOW:
				return ($urandom_range(9) == 0) ? lbpd_pkg::SAMPLE_W'($urandom)
					: lbpd_pkg::SAMPLE_W'($urandom_range(7));
			LEVEL_HIGH:
				return ($urandom_range(9) == 0) ? lbpd_pkg::SAMPLE_W'($urandom)
					: lbpd_pkg::FULL_SCALE - lbpd_pkg::SAMPLE_W'($urandom_range(7));
			default: begin
				case ($urandom_range(5))
					0:       return '0;
					1:       return lbpd_pkg::FULL_SCALE;
					default: return lbpd_pkg::SAMPLE_W'($urandom);
				endcase
			end
		endcase
	endfunction

	initial begin
		logic [lbpd_pkg::NUM_LEDS-1:0][2:0] phase_modes;
		int                                 items;
		level_t                             level;
		bit                                 with_hold;

		// model reset state
		for (int n = 0; n < lbpd_pkg::NUM_LEDS; n++)
			mode_reg[n] = lbpd_pkg::MODE_RESET;
		for (int p = 0; p < lbpd_pkg::NUM_PATTERNS; p++)
			pat_count[p] = '0;
		comp_phase = lbpd_pkg::PH_SLOW;
		comp_reps = '0;
		sample_div = '0;
		filt_low = lbpd_pkg::FULL_SCALE;
		filt_high = lbpd_pkg::FULL_SCALE;
		duty_low = lbpd_pkg::DUTY_RESET;
		duty_high = lbpd_pkg::DUTY_RESET;

		// directed ticks; want is {bright_high, bright_low, lit_mask}
		// reset modes are all off, duties sit at their reset value until the fifth tick
		dir_rows[0]  = '{12'd0,    12'd0,    1'b1,
			{lbpd_pkg::DUTY_RESET, lbpd_pkg::DUTY_RESET, 8'h00}};
		dir_rows[1]  = '{12'd4095, 12'd4095, 1'b1,
			{lbpd_pkg::DUTY_RESET, lbpd_pkg::DUTY_RESET, 8'h00}};
		dir_rows[2]  = '{12'd0,    12'd4095, 1'b1,
			{lbpd_pkg::DUTY_RESET, lbpd_pkg::DUTY_RESET, 8'h00}};
		dir_rows[3]  = '{12'd4095, 12'd0,    1'b1,
			{lbpd_pkg::DUTY_RESET, lbpd_pkg::DUTY_RESET, 8'h00}};
		// first filter update from full scale: zero sample -> 3583, full sample -> 4094
		dir_rows[4]  = '{12'd0,    12'd4095, 1'b1, {8'd249, 8'd218, 8'h00}};
		// from here every pattern and both undefined modes are on show
		dir_rows[5]  = '{12'd4095, 12'd4095, 1'b0, '0};
		dir_rows[6]  = '{12'h555,  12'hAAA,  1'b0, '0};
		dir_rows[7]  = '{12'hAAA,  12'h555,  1'b0, '0};
		dir_rows[8]  = '{12'd0,    12'd0,    1'b0, '0};
		dir_rows[9]  = '{12'd1,    12'd4094, 1'b0, '0};
		dir_rows[10] = '{12'd4094, 12'd1,    1'b0, '0};
		dir_rows[11] = '{12'd7,    12'd8,    1'b0, '0};
		dir_rows[12] = '{12'd8,    12'd7,    1'b0, '0};
		dir_rows[13] = '{12'h800,  12'h7FF,  1'b0, '0};
		dir_rows[14] = '{12'h7FF,  12'h800,  1'b0, '0};
		dir_rows[15] = '{12'd4095, 12'd0,    1'b0, '0};
		dir_rows[16] = '{12'd0,    12'd4095, 1'b0, '0};
		dir_rows[17] = '{12'h0F0,  12'hF0F,  1'b0, '0};
		dir_rows[18] = '{12'hF0F,  12'h0F0,  1'b0, '0};
		dir_rows[19] = '{12'd4095, 12'd4095, 1'b0, '0};
		dir_rows[20] = '{12'd0,    12'd0,    1'b0, '0};
		dir_rows[21] = '{12'd2048, 12'd2047, 1'b0, '0};
		dir_rows[22] = '{12'd4088, 12'd15,   1'b0, '0};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (r == DIR_CFG_AT) begin
				wait_drained();
				load_modes({MODE_UNDEF_HI, MODE_UNDEF_LO, lbpd_pkg::PAT_COMPOSITE,
					lbpd_pkg::PAT_FAST, lbpd_pkg::PAT_MEDIUM, lbpd_pkg::PAT_SLOW,
					lbpd_pkg::PAT_OFF, lbpd_pkg::PAT_ON});
			end
			push_tick(dir_rows[r].lo, dir_rows[r].hi, dir_rows[r].pinned, dir_rows[r].want);
		end

		// random phases: new modes, idling style and sample level each time
		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int n = 0; n < lbpd_pkg::NUM_LEDS; n++)
				phase_modes[n] = 3'($urandom_range(7));
			items = 130;
			level = LEVEL_MIXED;
			with_hold = 1'b0;
			case (p)
				0: begin
					phase_modes = {lbpd_pkg::NUM_LEDS{lbpd_pkg::PAT_ON}};
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					phase_modes = {lbpd_pkg::NUM_LEDS{lbpd_pkg::PAT_COMPOSITE}};
					tx_idle_pct = 58;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 58;
					level = LEVEL_LOW;
					items = 300;
				end
				3: begin
					phase_modes = {lbpd_pkg::NUM_LEDS{MODE_UNDEF_HI}};
					tx_idle_pct = 12;
					rx_stall_pct = 12;
					level = LEVEL_HIGH;
				end
				4: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					with_hold = 1'b1;
				end
				5: begin
					tx_idle_pct = 12;
					rx_stall_pct = 12;
				end
				6: begin
					tx_idle_pct = 58;
					rx_stall_pct = 0;
					level = LEVEL_LOW;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 58;
					level = LEVEL_HIGH;
				end
			endcase
			wait_drained();
			load_modes(phase_modes);
			for (int k = 0; k < items; k++) begin
				// result side holds off while ticks keep coming, so the input backs up
				if (with_hold && k == 20)
					hold_req = 1'b1;
				push_tick(pick_sample(level), pick_sample(level), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
